[rtl/assert_macros.svh]
// assertion macros shared by the rng modules
// no dependencies; the bodies fall away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is held low
`define CLSR_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check with no reset qualifier
`define CLSR_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLSR_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define CLSR_ASSERT(lbl, clk, prop, msg)
`endif
`endif

[rtl/clsr_pkg.sv]
// constants and controller/datapath interface types of the combined lcg rng
// no dependencies
package clsr_pkg;

    localparam int DEF_TABLE_DEPTH  = 32;
    localparam int DEF_WARMUP_STEPS = 8;

    localparam logic [31:0] MOD1       = 32'd2147483563;
    localparam logic [31:0] MOD2       = 32'd2147483399;
    localparam logic [15:0] MUL1       = 16'd40014;
    localparam logic [15:0] MUL2       = 16'd40692;
    localparam logic [31:0] WRAP_ADD   = 32'd2147483562;
    localparam logic [31:0] FRAC_MAX   = 32'd4294966780;
    localparam logic [30:0] SEED_INIT2 = 31'd123456789;
    // 2^31 mod MOD1 and 2^31 mod MOD2
    localparam logic [7:0]  FOLD1      = 8'd85;
    localparam logic [7:0]  FOLD2      = 8'd249;
    // 2^32 mod MOD1, used by the fraction
    localparam logic [7:0]  FRAC_K     = 8'd170;

    typedef struct packed {
        logic accept;
        logic mul;
        logic red1;
        logic red2;
        logic fill_we;
        logic fill_last;
        logic div_init;
        logic div_step;
        logic div_fix;
        logic ram_re;
        logic slot_we;
        logic iy_load;
        logic frac_mul;
        logic out_load;
    } clsr_cmd_t;

    typedef struct packed {
        logic in_reload;
        logic out_free;
    } clsr_stat_t;

endpackage

[rtl/clsr_ram.sv]
// generic single write port ram with registered read
// no dependencies
module clsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/clsr_ctrl.sv]
// sequencer for seeding, table fill and draws of the combined lcg rng
// depends on clsr_pkg and assert_macros.svh
`include "assert_macros.svh"
module clsr_ctrl #(
    parameter int TABLE_DEPTH  = clsr_pkg::DEF_TABLE_DEPTH,
    parameter int WARMUP_STEPS = clsr_pkg::DEF_WARMUP_STEPS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  clsr_pkg::clsr_stat_t           stat,
    output clsr_pkg::clsr_cmd_t            cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] fill_addr
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + WARMUP_STEPS + 1);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_RL_MUL  = 10'b0000000010,
        S_RL_RED  = 10'b0000000100,
        S_D_MUL   = 10'b0000001000,
        S_D_RED   = 10'b0000010000,
        S_D_DIV   = 10'b0000100000,
        S_D_READ  = 10'b0001000000,
        S_D_WRITE = 10'b0010000000,
        S_D_FRAC  = 10'b0100000000,
        S_D_OUT   = 10'b1000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    if (stat.in_reload) begin
                        cnt_next   = CNT_W'(TABLE_DEPTH + WARMUP_STEPS - 1);
                        state_next = S_RL_MUL;
                    end else begin
                        state_next = S_D_MUL;
                    end
                end
            end
            S_RL_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_RL_RED;
            end
            S_RL_RED: begin
                cmd.red1    = 1'b1;
                cmd.fill_we = (cnt_reg < CNT_W'(TABLE_DEPTH));
                if (cnt_reg == '0) begin
                    cmd.fill_last = 1'b1;
                    state_next    = S_D_MUL;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_RL_MUL;
                end
            end
            S_D_MUL: begin
                cmd.mul      = 1'b1;
                cmd.div_init = 1'b1;
                state_next   = S_D_RED;
            end
            S_D_RED: begin
                cmd.red1     = 1'b1;
                cmd.red2     = 1'b1;
                cmd.div_step = 1'b1;
                state_next   = S_D_DIV;
            end
            S_D_DIV: begin
                cmd.div_fix = 1'b1;
                state_next  = S_D_READ;
            end
            S_D_READ: begin
                cmd.ram_re = 1'b1;
                state_next = S_D_WRITE;
            end
            S_D_WRITE: begin
                cmd.slot_we = 1'b1;
                cmd.iy_load = 1'b1;
                state_next  = S_D_FRAC;
            end
            S_D_FRAC: begin
                cmd.frac_mul = 1'b1;
                state_next   = S_D_OUT;
            end
            S_D_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign fill_addr = cnt_reg[IDX_W-1:0];

    // the table port is never read and written in the same cycle
    `CLSR_ASSERT_RST(a_ram_port_excl, aclk, aresetn, !(cmd.ram_re && (cmd.slot_we || cmd.fill_we)), "table read and write collide")
    // the last fill step always hands over to a draw
    `CLSR_ASSERT_RST(a_fill_to_draw, aclk, aresetn, (state_reg == S_RL_RED) && (cnt_reg == '0) |=> (state_reg == S_D_MUL), "fill did not end in a draw")

endmodule

[rtl/clsr_dpath.sv]
// generator states, modular reduction, slot divider, shuffle table and output
// depends on clsr_pkg, clsr_ram and assert_macros.svh
`include "assert_macros.svh"
module clsr_dpath #(
    parameter int TABLE_DEPTH = clsr_pkg::DEF_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  clsr_pkg::clsr_cmd_t            cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] fill_addr,
    input  logic [31:0]                    s_tdata,
    input  logic [0:0]                     s_tuser,
    output clsr_pkg::clsr_stat_t           stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [95:0]                    m_tdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned SLOT_DIV = 1 + clsr_pkg::WRAP_ADD / TABLE_DEPTH;
    localparam logic [32:0] SLOT_LIMIT = 33'(SLOT_DIV) * 33'(TABLE_DEPTH);
    // floor(2^31 / SLOT_DIV), at most 256 over the allowed depths
    localparam longint unsigned RECIP = 64'h8000_0000 / SLOT_DIV;

    function automatic logic [30:0] mod_fold(input logic [46:0] p, input logic [31:0] m,
                                             input logic [7:0] k);
        logic [31:0] s;
        s = {1'b0, p[30:0]} + 32'(p[46:31]) * 32'(k);
        if (s >= m) begin
            s = s - m;
        end
        return s[30:0];
    endfunction

    // architectural state
    logic [30:0]            x1_reg, x1_next;
    logic [30:0]            x2_reg, x2_next;
    logic [30:0]            last_reg, last_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                   m_valid_reg, m_valid_next;
    // working registers
    logic [46:0]            p1_reg, p1_next;
    logic [46:0]            p2_reg, p2_next;
    logic [30:0]            rem_reg, rem_next;
    logic [IDX_W-1:0]       quot_reg, quot_next;
    logic                   clamp_reg, clamp_next;
    logic                   vrd_reg, vrd_next;
    logic [38:0]            t_reg, t_next;
    logic [95:0]            m_data_reg, m_data_next;

    logic              seed_nonpos;
    logic [31:0]       seed_neg;
    logic [30:0]       seed_mag;
    logic [30:0]       red1_val, red2_val;
    logic [39:0]       est_prod;
    logic [39:0]       back_prod;
    logic [39:0]       rem_full;
    logic              div_ge;
    logic [IDX_W-1:0]  slot;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [30:0]       ram_wdata;
    logic [30:0]       ram_rdata;
    logic [30:0]       entry;
    logic [32:0]       wrap_sum;
    logic [30:0]       iy;
    logic [7:0]        t_hi;
    logic [31:0]       t_fold;
    logic              t_carry;
    logic [33:0]       frac_full;
    logic [31:0]       frac;

    // seed decode: zero or negative means a full reload
    assign seed_nonpos    = (s_tdata == '0) || s_tdata[31];
    assign seed_neg       = ~s_tdata + 32'd1;
    assign seed_mag       = (s_tdata == '0) ? 31'd1 :
                            (seed_neg[31] ? 31'h7FFFFFFF : seed_neg[30:0]);
    assign stat.in_reload = s_tuser[0] && seed_nonpos;
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign red1_val = mod_fold(p1_reg, clsr_pkg::MOD1, clsr_pkg::FOLD1);
    assign red2_val = mod_fold(p2_reg, clsr_pkg::MOD2, clsr_pkg::FOLD2);

    // slot divide: reciprocal estimate is low by at most one, then one correction
    assign est_prod  = 40'(last_reg) * 40'(RECIP);
    assign back_prod = 40'(quot_reg) * 40'(SLOT_DIV);
    assign rem_full  = 40'(last_reg) - back_prod;
    assign div_ge    = ({1'b0, rem_reg} >= 32'(SLOT_DIV));
    assign slot      = clamp_reg ? IDX_W'(TABLE_DEPTH - 1) : quot_reg;

    assign ram_we    = cmd.fill_we || cmd.slot_we;
    assign ram_waddr = cmd.fill_we ? fill_addr : slot;
    assign ram_wdata = cmd.fill_we ? red1_val : x1_reg;

    clsr_ram #(
        .WIDTH (31),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.ram_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    // never written entries read as zero
    assign entry    = vrd_reg ? ram_rdata : '0;
    assign wrap_sum = {2'b00, entry} + 33'(clsr_pkg::WRAP_ADD) - {2'b00, x2_reg};
    assign iy       = (entry > x2_reg) ? (entry - x2_reg) : wrap_sum[30:0];

    // iy * 2^32 / MOD1 = 2*iy + floor(170*iy / MOD1)
    assign t_hi      = t_reg[38:31];
    assign t_fold    = 32'(t_hi) * 32'(clsr_pkg::FOLD1) + {1'b0, t_reg[30:0]};
    assign t_carry   = (t_fold >= clsr_pkg::MOD1);
    assign frac_full = {2'b00, last_reg, 1'b0} + 34'(t_hi) + 34'(t_carry);
    assign frac      = (frac_full > 34'(clsr_pkg::FRAC_MAX)) ? clsr_pkg::FRAC_MAX
                                                             : frac_full[31:0];

    always_comb begin
        x1_next      = x1_reg;
        x2_next      = x2_reg;
        last_next    = last_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        clamp_next   = clamp_reg;
        vrd_next     = vrd_reg;
        t_next       = t_reg;
        m_data_next  = m_data_reg;

        if (cmd.accept && s_tuser[0]) begin
            if (seed_nonpos) begin
                x1_next = seed_mag;
                x2_next = seed_mag;
            end else begin
                x1_next = s_tdata[30:0];
            end
        end
        if (cmd.mul) begin
            p1_next = 47'(x1_reg) * 47'(clsr_pkg::MUL1);
            p2_next = 47'(x2_reg) * 47'(clsr_pkg::MUL2);
        end
        if (cmd.red1) begin
            x1_next = red1_val;
        end
        if (cmd.red2) begin
            x2_next = red2_val;
        end
        if (cmd.fill_last) begin
            last_next = red1_val;
        end
        if (cmd.div_init) begin
            quot_next  = est_prod[IDX_W+30:31];
            clamp_next = ({2'b00, last_reg} >= SLOT_LIMIT);
        end
        if (cmd.div_step) begin
            rem_next = rem_full[30:0];
        end
        if (cmd.div_fix) begin
            quot_next = quot_reg + IDX_W'(div_ge);
        end
        if (cmd.ram_re) begin
            vrd_next = valid_reg[slot];
        end
        if (ram_we) begin
            valid_next[ram_waddr] = 1'b1;
        end
        if (cmd.iy_load) begin
            last_next = iy;
        end
        if (cmd.frac_mul) begin
            t_next = 39'(last_reg) * 39'(clsr_pkg::FRAC_K);
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {2'b00, x1_reg, frac, last_reg};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg      <= 31'd1;
            x2_reg      <= clsr_pkg::SEED_INIT2;
            last_reg    <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            x1_reg      <= x1_next;
            x2_reg      <= x2_next;
            last_reg    <= last_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        clamp_reg  <= clamp_next;
        vrd_reg    <= vrd_next;
        t_reg      <= t_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // the folded reduction always lands below the modulus
    `CLSR_ASSERT_RST(a_x1_in_range, aclk, aresetn, cmd.red1 |=> (x1_reg < clsr_pkg::MOD1), "first state not reduced")
    `CLSR_ASSERT_RST(a_x2_in_range, aclk, aresetn, cmd.red2 |=> (x2_reg < clsr_pkg::MOD2), "second state not reduced")
    // the shuffled output can never be zero
    `CLSR_ASSERT_RST(a_iy_nonzero, aclk, aresetn, cmd.iy_load |=> (last_reg != '0), "shuffled output is zero")

endmodule

[rtl/combined_lcg_shuffle_rng.sv]
// a draw runs the generator multiply and fold, the reciprocal slot divide and its correction,
// the table read-modify-write and the fraction multiply, then loads the registered output,
//   waiting on m_tready while that register is full; s_tready stays low until the load
// a reloading seed first runs the table fill steps before its draw
// reset: synchronous active-low aresetn restores the stock seeds and marks the table empty
// depends on clsr_pkg, clsr_ctrl, clsr_dpath and assert_macros.svh
`include "assert_macros.svh"
module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH  = clsr_pkg::DEF_TABLE_DEPTH,
    parameter int WARMUP_STEPS = clsr_pkg::DEF_WARMUP_STEPS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed_value (signed)
    input  logic [0:0]  s_tuser,   // [0] func
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // [30:0] random_integer, [62:31] random_fraction,
                                   // [93:63] seed_after, [95:94] zero
);

    // controller to datapath commands and status flags
    clsr_pkg::clsr_cmd_t            cmd;
    clsr_pkg::clsr_stat_t           stat;
    logic [$clog2(TABLE_DEPTH)-1:0] fill_addr;

    // sequencer: idle, table fill loop, then the draw steps
    clsr_ctrl #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .WARMUP_STEPS (WARMUP_STEPS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .stat      (stat),
        .cmd       (cmd),
        .fill_addr (fill_addr)
    );

    // generators, divider, shuffle table and the output register
    clsr_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .fill_addr (fill_addr),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a draw runs through its steps before the sequencer returns to idle, so no beat directly follows another
    `CLSR_ASSERT_RST(a_no_back_to_back, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "input beat taken while busy")

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// stream-level testbench of combined_lcg_shuffle_rng: directed and random draw/seed beats
// against an in-bench predictor of the shuffled combined generator
// depends on the rtl sources only (combined_lcg_shuffle_rng and what it pulls in)
module testbench;

    // predictor sizes and constants, matched to the instance parameters below
    localparam int          SHUF_DEPTH = 32;
    localparam int          WARMUP     = 8;
    localparam logic [63:0] MOD_A      = 64'd2147483563;
    localparam logic [63:0] MOD_B      = 64'd2147483399;
    localparam logic [63:0] MUL_A      = 64'd40014;
    localparam logic [63:0] MUL_B      = 64'd40692;
    localparam logic [63:0] WRAP_ADD   = 64'd2147483562;
    localparam logic [63:0] FRAC_CAP   = 64'd4294966780;
    localparam logic [63:0] SLOT_DIV   = 64'd1 + (MOD_A - 64'd1) / SHUF_DEPTH;
    localparam logic [30:0] GEN_B_INIT = 31'd123456789;

    // request kinds carried on tuser
    localparam logic FN_DRAW = 1'b0;
    localparam logic FN_SEED = 1'b1;

    localparam int RANDOM_ITEMS = 1750;
    localparam int MAX_WAIT     = 17;
    // leave room for the fill steps of a reloading seed plus the pipe
    localparam int TAIL_CYCLES  = 2 * (SHUF_DEPTH + WARMUP) + 40;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic        func;
        logic [31:0] seed;
    } rng_req_t;

    typedef struct packed {
        logic [30:0] iy;
        logic [31:0] frac;
        logic [30:0] gen_a;
    } rng_draw_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] seed_value (signed)
    logic [0:0]  s_tuser  = '0;    // [0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;          // [30:0] random_integer, [62:31] random_fraction,
                                   // [93:63] seed_after, [95:94] zero

    combined_lcg_shuffle_rng #(
        .TABLE_DEPTH  (SHUF_DEPTH),
        .WARMUP_STEPS (WARMUP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 8 ns period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor state: both generators, last output and shuffle table
    // ---------------------------------------------------------------
    logic [30:0] gen_a;
    logic [30:0] gen_b;
    logic [30:0] prev_iy;
    logic [30:0] shuffle [SHUF_DEPTH];

    rng_req_t  pending_items [$];   // beats still to be driven
    rng_draw_t pending_draws [$];   // expected result beats, oldest first

    int  in_beats;      // accepted input beats
    int  out_beats;     // accepted result beats
    int  issued;        // input beats presented by the driver
    int  total_items;
    int  fail_count;
    int  cycle_count;
    int  send_wait;
    int  recv_wait;
    int  recv_seen;
    bit  send_burst;
    bit  recv_burst;

    function automatic logic [30:0] lcg_a_next(input logic [30:0] x);
        logic [63:0] prod;
        prod = 64'(x) * MUL_A;
        return 31'(prod % MOD_A);
    endfunction

    function automatic logic [30:0] lcg_b_next(input logic [30:0] x);
        logic [63:0] prod;
        prod = 64'(x) * MUL_B;
        return 31'(prod % MOD_B);
    endfunction

    // idle cycles before the next beat; now and then flip into or out of a burst stretch
    function automatic int wait_cycles(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic rng_reset();
        gen_a   = 31'd1;
        gen_b   = GEN_B_INIT;
        prev_iy = '0;
        for (int k = 0; k < SHUF_DEPTH; k++)
            shuffle[k] = '0;
    endtask

    // advance the predictor by one accepted beat and return the draw it yields
    task automatic rng_draw(input rng_req_t req, output rng_draw_t res);
        logic [63:0] mag;
        logic [63:0] slot;
        logic [63:0] diff;
        logic [63:0] quot;
        logic [30:0] entry;
        logic [30:0] iy;
        if (req.func == FN_SEED) begin
            if (req.seed == 32'd0 || req.seed[31]) begin
                // zero or negative seed: reload both generators and refill the table
                mag = (req.seed == 32'd0) ? 64'd1 : 64'h1_0000_0000 - 64'(req.seed);
                // the most negative seed does not fit 31 bits, saturate it
                if (mag > 64'h7FFF_FFFF)
                    mag = 64'h7FFF_FFFF;
                gen_a = mag[30:0];
                gen_b = mag[30:0];
                for (int j = SHUF_DEPTH + WARMUP - 1; j >= 0; j--) begin
                    gen_a = lcg_a_next(gen_a);
                    if (j < SHUF_DEPTH)
                        shuffle[j] = gen_a;
                end
                prev_iy = shuffle[0];
            end else begin
                // positive seed only replaces the first state, even above the modulus
                gen_a = req.seed[30:0];
            end
        end
        gen_a = lcg_a_next(gen_a);
        gen_b = lcg_b_next(gen_b);

        slot = 64'(prev_iy) / SLOT_DIV;
        if (slot > SHUF_DEPTH - 1)
            slot = SHUF_DEPTH - 1;
        entry = shuffle[slot];
        shuffle[slot] = gen_a;

        // difference below one wraps back into range
        if (entry > gen_b)
            diff = 64'(entry) - 64'(gen_b);
        else
            diff = 64'(entry) + WRAP_ADD - 64'(gen_b);
        iy = diff[30:0];
        prev_iy = iy;

        quot = {1'b0, iy, 32'd0} / MOD_A;
        if (quot > FRAC_CAP)
            quot = FRAC_CAP;

        res.iy    = iy;
        res.frac  = quot[31:0];
        res.gen_a = gen_a;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic rng_req_t mk_req(input logic func, input logic [31:0] seed);
        rng_req_t r;
        r.func = func;
        r.seed = seed;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // driver: presents queued beats at the falling edge with random gaps
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_wait = wait_cycles(send_burst);
        end else if (!(s_tvalid && in_beats != issued)) begin
            // nothing outstanding: either idle out the gap or put up the next beat
            if (send_wait > 0) begin
                send_wait--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_tdata  <= pending_items[0].seed;
                s_tuser  <= pending_items[0].func;
                s_tvalid <= 1'b1;
                void'(pending_items.pop_front());
                issued++;
                send_wait = wait_cycles(send_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result side ready: random stall after every result beat
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait = wait_cycles(recv_burst);
        end else begin
            if (out_beats != recv_seen) begin
                recv_seen = out_beats;
                recv_wait = wait_cycles(recv_burst);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: handshakes sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        rng_draw_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_draws.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = pending_draws.pop_front();
                    check_field("random_integer", 32'(want.iy), 32'(m_tdata[30:0]));
                    check_field("random_fraction", want.frac, m_tdata[62:31]);
                    check_field("seed_after", 32'(want.gen_a), 32'(m_tdata[93:63]));
                    check_field("pad bits", 32'd0, 32'(m_tdata[95:94]));
                end
                out_beats++;
            end
            if (s_tvalid && s_tready) begin
                rng_draw(mk_req(s_tuser[0], s_tdata), want);
                pending_draws.push_back(want);
                in_beats++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        logic        fn;
        logic [31:0] sv;
        int          pick;
        rng_reset();

        // draws straight out of reset hit the all-zero table at slot 0
        pending_items.push_back(mk_req(FN_DRAW, 32'h0000_0000));
        pending_items.push_back(mk_req(FN_DRAW, 32'hFFFF_FFFF));
        // zero seed reloads with magnitude one
        pending_items.push_back(mk_req(FN_SEED, 32'h0000_0000));
        pending_items.push_back(mk_req(FN_DRAW, 32'h5555_5555));
        pending_items.push_back(mk_req(FN_SEED, 32'hFFFF_FFFF));
        // most negative seed saturates the magnitude
        pending_items.push_back(mk_req(FN_SEED, 32'h8000_0000));
        pending_items.push_back(mk_req(FN_SEED, 32'h8000_0001));
        pending_items.push_back(mk_req(FN_DRAW, 32'hAAAA_AAAA));
        pending_items.push_back(mk_req(FN_SEED, 32'h0000_0001));
        pending_items.push_back(mk_req(FN_SEED, 32'h7FFF_FFFF));
        pending_items.push_back(mk_req(FN_DRAW, 32'h0000_0000));
        // seed equal to the first modulus pins the first generator at zero
        pending_items.push_back(mk_req(FN_SEED, 32'd2147483563));
        pending_items.push_back(mk_req(FN_DRAW, 32'h0000_0000));
        pending_items.push_back(mk_req(FN_DRAW, 32'hFFFF_FFFF));
        pending_items.push_back(mk_req(FN_SEED, 32'd2147483562));
        pending_items.push_back(mk_req(FN_SEED, 32'd2147483564));
        pending_items.push_back(mk_req(FN_SEED, 32'hAAAA_AAAA));
        pending_items.push_back(mk_req(FN_SEED, 32'h5555_5555));
        for (int k = 0; k < 4; k++)
            pending_items.push_back(mk_req(FN_DRAW, $urandom));

        // random part: mostly draws, with a sprinkling of reseeds of every kind
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            fn = ($urandom_range(0, 9) == 0) ? FN_SEED : FN_DRAW;
            sv = $urandom;
            if (fn == FN_SEED) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    sv = 32'd0;
                else if (pick < 9)
                    sv[31] = 1'b1;
                else if (pick < 11)
                    sv = 32'd2147483563 + $urandom_range(0, 84) - 32'd42;
                else
                    sv[31] = 1'b0;
            end
            pending_items.push_back(mk_req(fn, sv));
        end
        total_items = pending_items.size();

        // reset held low at the start, released at a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (in_beats < total_items || pending_draws.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
